>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define SCMD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is held
`define SCMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that is also checked across reset
`define SCMD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/scmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scmd_pkg;

  typedef enum logic [1:0] {
    ACT_READ_WORD  = 2'd0,
    ACT_READ_BYTE  = 2'd1,
    ACT_WRITE_WORD = 2'd2,
    ACT_WRITE_BYTE = 2'd3
  } action_t;

  typedef struct packed {
    logic ram_write_ok;
    logic ram_read_ok;
    logic rom_read_ok;
  } flags_t;

  localparam logic [15:0] WIN_LO      = 16'o164000;
  localparam logic [15:0] WIN_HI      = 16'o165777;
  localparam logic [15:0] ROM_HI      = 16'o157777;
  localparam logic [15:0] IO_ROM_LO   = 16'o160000;
  localparam logic [15:0] IO_ROM_HI   = 16'o163777;
  localparam logic [15:0] HI_ROM_LO   = 16'o166000;
  localparam logic [15:0] HI_ROM_HI   = 16'o176777;
  localparam logic [15:0] ROM_OFF_BIT = 16'o020000;
  localparam logic [15:0] IO_ROM_BIT  = 16'o001000;

  function automatic logic [15:0] ram_end(input logic [1:0] sel);
    logic [15:0] r;
    unique case (sel)
      2'd0: r = 16'o157777;
      2'd1: r = 16'o077777;
      2'd2: r = 16'o037777;
      default: r = 16'o017777;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] rom_start(input logic [2:0] code);
    logic [15:0] r;
    unique case (code)
      3'd0: r = 16'o177777;
      3'd1: r = 16'o100000;
      3'd2: r = 16'o040000;
      3'd3: r = 16'o020000;
      default: r = 16'o000000;
    endcase
    return r;
  endfunction

  function automatic flags_t decode(input logic [15:0] one, input logic [15:0] two,
                                    input logic [15:0] addr);
    flags_t f;
    logic   in_win;
    logic   main_rom;
    logic   io_rom;
    logic   hi_rom;
    in_win   = (addr >= WIN_LO) && (addr <= WIN_HI);
    main_rom = (one[13:11] != 3'd0) && (addr >= rom_start(one[13:11])) && (addr <= ROM_HI);
    io_rom   = ((two & IO_ROM_BIT) != 16'd0) && (addr >= IO_ROM_LO) && (addr <= IO_ROM_HI);
    hi_rom   = (addr >= HI_ROM_LO) && (addr <= HI_ROM_HI);
    f.ram_write_ok = (addr <= ram_end(one[10:9])) || in_win;
    f.ram_read_ok  = (!one[13] && (addr <= ram_end(one[12:11]))) || in_win;
    f.rom_read_ok  = ((two & ROM_OFF_BIT) == 16'd0) && (main_rom || io_rom || hi_rom);
    return f;
  endfunction

endpackage
`default_nettype wire

>>> rtl/scmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// bus access channel
interface scmd_in_if;
  logic                  valid;
  logic                  ready;
  scmd_pkg::action_t     action;
  logic [1:0]            offset;
  logic [15:0]           write_data;
  logic [15:0]           address;

  modport source (output valid, action, offset, write_data, address, input ready);
  modport sink (input valid, action, offset, write_data, address, output ready);
endinterface

// result channel
interface scmd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        ram_write_ok;
  logic        ram_read_ok;
  logic        rom_read_ok;

  modport source (output valid, read_data, ram_write_ok, ram_read_ok, rom_read_ok,
                  input ready);
  modport sink (input valid, read_data, ram_write_ok, ram_read_ok, rom_read_ok,
                output ready);
endinterface
`default_nettype wire

>>> rtl/system_controller_memory_decode_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  fields
// in_ch     in   action, offset, write_data, address
// out_ch    out  read_data, ram_write_ok, ram_read_ok, rom_read_ok
//
// one item per clock sustained while out_ch.ready is high; each item passes through
// the input register and leaves through the result register, offered there until taken
// decode and register access are combinational between those two registers
// rst_n is synchronous, active low, and clears both control registers and all valids
// when the result is stalled the input register holds one more item, then ready drops
module system_controller_memory_decode_core (
  input  wire          clk,
  input  wire          rst_n,
  scmd_in_if.sink      in_ch,
  scmd_out_if.source   out_ch
);

  // input register
  logic              s1_valid_r;
  scmd_pkg::action_t s1_action_r;
  logic [1:0]        s1_offset_r;
  logic [15:0]       s1_data_r;
  logic [15:0]       s1_addr_r;

  // control registers
  logic [15:0] reg_one_r, reg_one_nxt;
  logic [15:0] reg_two_r, reg_two_nxt;

  // result register
  logic             out_valid_r;
  logic [15:0]      out_rdata_r, out_rdata_nxt;
  scmd_pkg::flags_t out_flags_r, out_flags_nxt;

  logic        adv;
  logic        in_take;
  logic [15:0] cur;
  logic [15:0] merged;

  // the input register moves on whenever the result register is free or draining
  assign adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid_r || !out_valid_r || out_ch.ready;

  always_comb begin
    // offset bit 1 selects the second register, bit 0 the high byte lane
    cur    = s1_offset_r[1] ? reg_two_r : reg_one_r;
    merged = s1_offset_r[0] ? {s1_data_r[7:0], cur[7:0]} : {cur[15:8], s1_data_r[7:0]};
    // decode sees the registers as they stand before this item's access
    out_flags_nxt = scmd_pkg::decode(reg_one_r, reg_two_r, s1_addr_r);
    out_rdata_nxt = 16'd0;
    reg_one_nxt   = reg_one_r;
    reg_two_nxt   = reg_two_r;
    unique case (s1_action_r)
      scmd_pkg::ACT_READ_WORD: begin
        out_rdata_nxt = cur;
      end
      scmd_pkg::ACT_READ_BYTE: begin
        out_rdata_nxt = s1_offset_r[0] ? {8'd0, cur[15:8]} : {8'd0, cur[7:0]};
      end
      scmd_pkg::ACT_WRITE_WORD: begin
        if (s1_offset_r[1]) reg_two_nxt = s1_data_r;
        else reg_one_nxt = s1_data_r;
      end
      scmd_pkg::ACT_WRITE_BYTE: begin
        if (s1_offset_r[1]) reg_two_nxt = merged;
        else reg_one_nxt = merged;
      end
      default: begin
        out_rdata_nxt = 16'd0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      reg_one_r   <= 16'd0;
      reg_two_r   <= 16'd0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (!out_valid_r || out_ch.ready) out_valid_r <= s1_valid_r;
      if (adv) begin
        reg_one_r <= reg_one_nxt;
        reg_two_r <= reg_two_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_ch.action;
      s1_offset_r <= in_ch.offset;
      s1_data_r   <= in_ch.write_data;
      s1_addr_r   <= in_ch.address;
    end
    if (adv) begin
      out_rdata_r <= out_rdata_nxt;
      out_flags_r <= out_flags_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_rdata_r;
  assign out_ch.ram_write_ok = out_flags_r.ram_write_ok;
  assign out_ch.ram_read_ok  = out_flags_r.ram_read_ok;
  assign out_ch.rom_read_ok  = out_flags_r.rom_read_ok;

endmodule
`default_nettype wire

>>> rtl/scmd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module scmd_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready
);

  // a stalled result stays offered
  `SCMD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // nothing comes out in the cycle after reset
  `SCMD_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid)

  // an empty result register never blocks the input side
  `SCMD_ASSERT_IMPLY(a_ready_free, clk, rst_n, !out_valid, in_ready)

  // a fresh result comes from an item that was taken and passed through the input register
  `SCMD_ASSERT_IMPLY(a_no_invent, clk, rst_n, out_valid && !$past(out_valid),
                     $past(in_valid && in_ready, 2))

endmodule

bind system_controller_memory_decode_core scmd_checker u_scmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
`default_nettype wire
